// ----- sv/rcfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfd_pkg: shared types and constants of the receiver frame decoder
// Frame layout, result word layout and configuration register map.
// ----------------------------------------------------------------------------
package rcfd_pkg;

    // Bytes in one complete receiver frame
    localparam int unsigned FRAME_LEN = 18;
    localparam int unsigned CNT_W     = 5;
    localparam logic [CNT_W-1:0] CNT_MAX   = 5'd31;
    localparam logic [CNT_W-1:0] CNT_FRAME = 5'(FRAME_LEN);

    // Input command codes (travel as tuser)
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_IDLE = 1'b1;

    // Configuration register map (index = paddr[2])
    localparam logic REG_CHANNEL_OFFSET    = 1'b0;
    localparam logic REG_STICK_ERROR_LIMIT = 1'b1;
    localparam logic [10:0] CHANNEL_OFFSET_RST    = 11'd1024;
    localparam logic [10:0] STICK_ERROR_LIMIT_RST = 11'd700;

    // Error-frame flag word: only the error bit set
    localparam logic [6:0] FLAGS_ERROR = 7'h40;

    typedef logic [FRAME_LEN-1:0][7:0] frame_t;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic [15:0]        key_new_press;
        logic [15:0]        key_bits;
        logic signed [15:0] mouse_z;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_x;
        logic [6:0]         flags;
        logic signed [15:0] dial_value;
        logic signed [10:0] stick_left_v;
        logic signed [10:0] stick_left_h;
        logic signed [10:0] stick_right_v;
        logic signed [10:0] stick_right_h;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);
    localparam int unsigned TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    // Frame handed from the front end to the queue
    typedef struct packed {
        logic   push;
        frame_t frame;
    } frame_push_t;

endpackage

`default_nettype wire

// ----- sv/rcfd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfd_front: byte collector
// Store incoming bytes, count them and hand a complete frame to the queue.
// ----------------------------------------------------------------------------
module rcfd_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_accept,
    input  wire logic                 in_cmd,
    input  wire logic [7:0]           in_byte,
    output rcfd_pkg::frame_push_t     push_o
);
    import rcfd_pkg::*;

    frame_t            bytes_reg;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (in_accept) begin
            if (in_cmd == CMD_IDLE) begin
                count_next = '0;
            end else if (count_reg < CNT_MAX) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Bytes past the frame length are not kept
    always_ff @(posedge aclk) begin
        if (in_accept && in_cmd == CMD_DATA && count_reg < CNT_FRAME) begin
            bytes_reg[count_reg] <= in_byte;
        end
    end

    assign push_o = '{push:  (in_accept && in_cmd == CMD_IDLE && count_reg == CNT_FRAME),
                      frame: bytes_reg};

endmodule

`default_nettype wire

// ----- sv/rcfd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfd_queue: two-entry frame queue
// Decouple byte collection from decoding.
// ----------------------------------------------------------------------------
module rcfd_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire rcfd_pkg::frame_push_t push_i,
    input  wire logic                 pop,
    output rcfd_pkg::frame_t          head,
    output logic                      not_empty,
    output logic                      full
);
    import rcfd_pkg::*;

    frame_t      mem [2];
    logic        wptr_reg, rptr_reg;
    logic [1:0]  fill_reg;

    always_ff @(posedge aclk) begin
        if (push_i.push) begin
            mem[wptr_reg] <= push_i.frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            if (push_i.push) wptr_reg <= ~wptr_reg;
            if (pop)         rptr_reg <= ~rptr_reg;
            fill_reg <= fill_reg + {1'b0, push_i.push} - {1'b0, pop};
        end
    end

    assign head      = mem[rptr_reg];
    assign not_empty = fill_reg != 2'd0;
    assign full      = fill_reg == 2'd2;

endmodule

`default_nettype wire

// ----- sv/rcfd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfd_back: frame unpacker
// Unpack a queued frame, check it and hold the result word for the sink.
// ----------------------------------------------------------------------------
module rcfd_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire rcfd_pkg::frame_t     head,
    input  wire logic                 not_empty,
    output logic                      pop,
    input  wire logic [10:0]          channel_offset,
    input  wire logic [10:0]          stick_error_limit,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rcfd_pkg::result_t         out_result
);
    import rcfd_pkg::*;

    logic               valid_reg;
    result_t            result_reg, result_next;
    logic [15:0]        prev_keys_reg, prev_keys_next;
    logic [3:0][10:0]   raw;
    logic [3:0][10:0]   stick;
    logic [3:0]         over;
    logic [1:0]         sw0, sw1;
    logic [15:0]        keys;
    logic               err;

    // Raw channel minus offset: range check and saturation to 11 bits
    function automatic logic [11:0] centre(input logic [10:0] r, input logic [10:0] off);
        centre = {1'b0, r} - {1'b0, off};
    endfunction

    function automatic logic stick_over(input logic [11:0] v, input logic [10:0] lim);
        logic [11:0] mag;
        mag = v[11] ? 12'(-v) : v;
        stick_over = mag > {1'b0, lim};
    endfunction

    function automatic logic [10:0] stick_sat(input logic [11:0] v);
        logic signed [11:0] sv;
        sv = $signed(v);
        if (sv > 12'sd1023) begin
            stick_sat = 11'h3FF;
        end else if (sv < -12'sd1024) begin
            stick_sat = 11'h400;
        end else begin
            stick_sat = v[10:0];
        end
    endfunction

    always_comb begin
        raw[0] = {head[1][2:0], head[0]};
        raw[1] = {head[2][5:0], head[1][7:3]};
        raw[2] = {head[4][0], head[3], head[2][7:6]};
        raw[3] = {head[5][3:0], head[4][7:1]};
        for (int i = 0; i < 4; i++) begin
            stick[i] = stick_sat(centre(raw[i], channel_offset));
            over[i]  = stick_over(centre(raw[i], channel_offset), stick_error_limit);
        end
        sw0  = head[5][5:4];
        sw1  = head[5][7:6];
        keys = {head[15], head[14]};
        err  = (|over) || sw0 == 2'd0 || sw1 == 2'd0;

        result_next = '0;
        prev_keys_next = '0;
        if (err) begin
            result_next.flags = FLAGS_ERROR;
        end else begin
            result_next.stick_right_h = stick[0];
            result_next.stick_right_v = stick[1];
            result_next.stick_left_h  = stick[2];
            result_next.stick_left_v  = stick[3];
            result_next.dial_value    = {head[17], head[16]} - {5'd0, channel_offset};
            result_next.flags         = {1'b0, |head[13], |head[12], sw1, sw0};
            result_next.mouse_x       = 16'(-{head[9], head[8]});
            result_next.mouse_y       = 16'(-{head[7], head[6]});
            result_next.mouse_z       = {head[11], head[10]};
            result_next.key_bits      = keys;
            result_next.key_new_press = keys & ~prev_keys_reg;
            prev_keys_next            = keys;
        end
    end

    // Load a new word when a frame is queued and the output slot is free or being emptied
    assign pop = not_empty && (!valid_reg || out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            prev_keys_reg <= '0;
        end else begin
            if (pop) begin
                valid_reg     <= 1'b1;
                prev_keys_reg <= prev_keys_next;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    a_error_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && result_reg.flags[6] |->
            result_reg.key_bits == '0 && result_reg.key_new_press == '0 &&
            result_reg.mouse_x == '0 && result_reg.dial_value == '0)
        else $error("error frame carries data");

    a_new_press_subset: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (result_reg.key_new_press & ~result_reg.key_bits) == '0)
        else $error("new key press not among held keys");

    a_error_clears_keys: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && err |=> prev_keys_reg == '0)
        else $error("previous keys kept after error frame");

endmodule

`default_nettype wire

// ----- sv/rc_receiver_frame_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc_receiver_frame_decoder: remote-control receiver frame decoder
// Collect receiver bytes, decode an 18-byte frame on line idle, emit one word.
// ----------------------------------------------------------------------------
// Result path: the idle marker that closes a full frame writes it into the
//   queue; it is decoded into the output register once the output slot is
//   free or being emptied, and m_tvalid is that register's valid bit.
// Throughput: one input word per cycle, set by the byte store and the
//   two-entry frame queue; a stalled sink backs up into s_tready only once
//   the queue and the output register are full.
// Reset: aresetn clears byte count, previous keys, queue and valid; the
//   registers return to offset 1024 and limit 700.
module rc_receiver_frame_decoder (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]                     s_tuser,   // [0] cmd
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [10:0] stick_right_h, [21:11] stick_right_v, [32:22] stick_left_h,
    // [43:33] stick_left_v, [59:44] dial_value, [66:60] flags,
    // [82:67] mouse_x, [98:83] mouse_y, [114:99] mouse_z,
    // [130:115] key_bits, [146:131] key_new_press, [151:147] zero
    output logic [rcfd_pkg::TDATA_W-1:0]        m_tdata,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [2:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import rcfd_pkg::*;

    logic          in_accept;
    frame_push_t   push;
    frame_t        head;
    logic          q_not_empty, q_full, q_pop;
    result_t       result;
    logic [10:0]   channel_offset_reg, stick_error_limit_reg;
    logic          cfg_write;

    // Hold off input only while the queue has no free entry
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    // Registers: written in the access phase, no wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_offset_reg    <= CHANNEL_OFFSET_RST;
            stick_error_limit_reg <= STICK_ERROR_LIMIT_RST;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_CHANNEL_OFFSET:    channel_offset_reg    <= pwdata[10:0];
                REG_STICK_ERROR_LIMIT: stick_error_limit_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_CHANNEL_OFFSET:    prdata = {21'd0, channel_offset_reg};
            REG_STICK_ERROR_LIMIT: prdata = {21'd0, stick_error_limit_reg};
            default:               prdata = '0;
        endcase
    end

    // Front end: store bytes, push complete frames
    rcfd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_cmd    (s_tuser[0]),
        .in_byte   (s_tdata),
        .push_o    (push)
    );

    // Queue between collection and decoding
    rcfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_i    (push),
        .pop       (q_pop),
        .head      (head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // Back end: decode and hold the result word
    rcfd_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head              (head),
        .not_empty         (q_not_empty),
        .pop               (q_pop),
        .channel_offset    (channel_offset_reg),
        .stick_error_limit (stick_error_limit_reg),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_result        (result)
    );

    // Pad the result word to whole bytes
    assign m_tdata = {{(TDATA_W - RESULT_W){1'b0}}, result};

endmodule

`default_nettype wire

// ----- sim/rc_receiver_frame_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_receiver_frame_decoder_tb: self-checking bench for the frame decoder
// Feed receiver bytes and idle markers through the input stream with random
// gaps. Change offset and limit over the APB port between quiet phases. Check
// every result word field by field against a frame decoder in the bench.
// ----------------------------------------------------------------------------
module rc_receiver_frame_decoder_tb;

    import rcfd_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int SETTLE_CYCLES = 4;       // queue and output register plus margin
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RAND_WORDS    = 375;

    // One directed case: the settings it runs under and the frame it sends
    typedef struct {
        logic [10:0] offset;
        logic [10:0] limit;
        frame_t      frame;
        int          nbytes;
        bit          with_idle;
        bit          typed_ok;
        result_t     typed;
    } dir_row_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = '0;
    logic [0:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b1;
    logic [TDATA_W-1:0]  m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [2:0]          paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Bench copy of the decoder state and its registers
    frame_t              rx_store  = '0;
    logic [CNT_W-1:0]    rx_count  = '0;
    logic [15:0]         held_keys = '0;
    logic [10:0]         cur_offset = CHANNEL_OFFSET_RST;
    logic [10:0]         cur_limit  = STICK_ERROR_LIMIT_RST;

    result_t             pending_results[$];
    dir_row_t            dir_rows[$];

    bit                  src_burst  = 1'b0;
    bit                  sink_burst = 1'b0;
    int unsigned         sink_hold;
    int unsigned         hold_left  = 0;
    int unsigned         cycle_count = 0;

    int                  fail_count     = 0;
    int                  words_sent     = 0;
    int                  frames_decoded = 0;
    int                  frames_flagged = 0;
    int                  frames_dropped = 0;
    int                  settings_used  = 0;

    rc_receiver_frame_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] rx_byte
        .s_tuser  (s_tuser),    // [0] cmd
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // result_t, stick_right_h lowest, zero padding on top
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Frame decoder of the bench. Store data words, decode on an idle marker
    // after exactly eighteen bytes; return 1 when a result word is due.
    // ------------------------------------------------------------------------
    function automatic bit decode_word(input logic cmd, input logic [7:0] rx,
                                       output result_t res);
        logic [143:0] flat;
        int           v;
        logic [10:0]  stick [4];
        logic [1:0]   sw0;
        logic [1:0]   sw1;
        logic [15:0]  keys;
        bit           bad;
        res = '0;
        if (cmd == CMD_DATA) begin
            // keep only the first eighteen bytes; saturate the count
            if (rx_count < CNT_FRAME) rx_store[rx_count] = rx;
            if (rx_count != CNT_MAX) rx_count = rx_count + 1'b1;
            return 1'b0;
        end
        if (rx_count != CNT_FRAME) begin
            rx_count = '0;
            return 1'b0;
        end
        rx_count = '0;
        flat = rx_store;
        bad  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            v = int'(flat[11*i +: 11]) - int'(cur_offset);
            if ((v < 0 ? -v : v) > int'(cur_limit)) bad = 1'b1;
            // a stick within a limit of 1024 may still overrun the field
            if (v > 1023) v = 1023;
            if (v < -1024) v = -1024;
            stick[i] = v[10:0];
        end
        sw0 = flat[45:44];
        sw1 = flat[47:46];
        if (sw0 == 2'd0 || sw1 == 2'd0) bad = 1'b1;
        if (bad) begin
            res.flags = FLAGS_ERROR;
            held_keys = '0;
            return 1'b1;
        end
        keys = flat[127:112];
        res.stick_right_h = stick[0];
        res.stick_right_v = stick[1];
        res.stick_left_h  = stick[2];
        res.stick_left_v  = stick[3];
        res.dial_value    = flat[143:128] - {5'd0, cur_offset};
        res.flags         = {1'b0, flat[111:104] != 8'd0, flat[103:96] != 8'd0, sw1, sw0};
        res.mouse_x       = 16'd0 - flat[79:64];
        res.mouse_y       = 16'd0 - flat[63:48];
        res.mouse_z       = flat[95:80];
        res.key_bits      = keys;
        res.key_new_press = keys & ~held_keys;
        held_keys = keys;
        return 1'b1;
    endfunction

    // Lay out one frame in byte order: four sticks and two switches in bytes
    // 0-5, mouse y, x and z raw, button bytes, keys, then the dial.
    function automatic frame_t pack_frame(
        input logic [10:0] c0, input logic [10:0] c1,
        input logic [10:0] c2, input logic [10:0] c3,
        input logic [1:0] s0, input logic [1:0] s1,
        input logic [15:0] my_raw, input logic [15:0] mx_raw, input logic [15:0] mz,
        input logic [7:0] lb, input logic [7:0] rb,
        input logic [15:0] keys, input logic [15:0] dial);
        return {dial, keys, rb, lb, mz, mx_raw, my_raw, s1, s0, c3, c2, c1, c0};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < 40)
            $display("%0t: MISMATCH %s got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(name, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Sender: wait a random gap, present one word, hold until accepted, then
    // advance the bench decoder. A typed row overrides the predicted word.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic cmd, input logic [7:0] rx,
                             input bit typed_ok, input result_t typed);
        int unsigned gap;
        result_t     predicted;
        gap = src_burst ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= rx;
        s_tuser[0] <= cmd;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if (decode_word(cmd, rx, predicted)) begin
            pending_results.push_back(typed_ok ? typed : predicted);
            if (predicted.flags[6]) frames_flagged++;
            else frames_decoded++;
        end else if (cmd == CMD_IDLE) begin
            frames_dropped++;
        end
    endtask

    // Send the first nbytes of a frame (random bytes past the eighteenth),
    // then optionally the idle marker with a random byte beside it.
    task automatic send_frame(input frame_t f, input int nbytes, input bit with_idle,
                              input bit typed_ok, input result_t typed);
        for (int i = 0; i < nbytes; i++)
            send_word(CMD_DATA, (i < FRAME_LEN) ? f[i] : 8'($urandom), 1'b0, '0);
        if (with_idle) send_word(CMD_IDLE, 8'($urandom), typed_ok, typed);
    endtask

    // Drop valid, wait for every expected word, then let the pipe run dry
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One APB transfer: setup cycle, access cycle, then idle
    task automatic apb_access(input logic write, input logic reg_idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Write both registers with junk above bit 10, then read them back
    task automatic set_regs(input logic [10:0] offset, input logic [10:0] limit);
        logic [31:0] rd;
        apb_access(1'b1, REG_CHANNEL_OFFSET, {21'($urandom), offset}, rd);
        cur_offset = offset;
        apb_access(1'b1, REG_STICK_ERROR_LIMIT, {21'($urandom), limit}, rd);
        cur_limit = limit;
        apb_access(1'b0, REG_CHANNEL_OFFSET, '0, rd);
        check_field("channel_offset readback", {21'd0, rd[10:0]}, {21'd0, offset});
        apb_access(1'b0, REG_STICK_ERROR_LIMIT, '0, rd);
        check_field("stick_error_limit readback", {21'd0, rd[10:0]}, {21'd0, limit});
        settings_used++;
    endtask

    task automatic add_row(input logic [10:0] offset, input logic [10:0] limit,
                           input frame_t f, input int nbytes, input bit with_idle,
                           input bit typed_ok, input result_t typed);
        dir_row_t r;
        r = '{offset, limit, f, nbytes, with_idle, typed_ok, typed};
        dir_rows.push_back(r);
    endtask

    task automatic compare_result(input result_t got, input result_t want);
        check_field("stick_right_h", got.stick_right_h, want.stick_right_h);
        check_field("stick_right_v", got.stick_right_v, want.stick_right_v);
        check_field("stick_left_h",  got.stick_left_h,  want.stick_left_h);
        check_field("stick_left_v",  got.stick_left_v,  want.stick_left_v);
        check_field("dial_value",    got.dial_value,    want.dial_value);
        check_field("flags",         got.flags,         want.flags);
        check_field("mouse_x",       got.mouse_x,       want.mouse_x);
        check_field("mouse_y",       got.mouse_y,       want.mouse_y);
        check_field("mouse_z",       got.mouse_z,       want.mouse_z);
        check_field("key_bits",      got.key_bits,      want.key_bits);
        check_field("key_new_press", got.key_new_press, want.key_new_press);
    endtask

    // ------------------------------------------------------------------------
    // Sink: check each accepted word against the oldest expectation, then
    // hold tready low for a random number of cycles before the next word.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0)
                report_mismatch("result word with nothing expected",
                                m_tdata[31:0], '0);
            else
                compare_result(m_tdata[RESULT_W-1:0], pending_results.pop_front());
            sink_hold = sink_burst ? 0 : $urandom_range(0, 8);
            m_tready  <= (sink_hold == 0);
            hold_left <= sink_hold;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= (hold_left == 1);
        end
    end

    // Watchdog: a hung handshake or a lost word ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words still expected",
                     $realtime, pending_results.size());
            $display("rc_receiver_frame_decoder_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, random phases, drain, verdict
    // ------------------------------------------------------------------------
    initial begin : main
        result_t     err_word;
        result_t     neutral_word;
        frame_t      f;
        logic [10:0] ch [4];
        logic [1:0]  sw [2];
        int          v;
        int          kind;
        int          phase;
        int          phase_start;

        err_word           = '0;
        err_word.flags     = FLAGS_ERROR;
        neutral_word       = '0;
        neutral_word.flags = 7'h05;          // both switches in position one

        // Directed cases. Typed words only where the answer is plain: the
        // neutral frame after reset and the flagged frames.
        add_row(1024, 700, '0, 0, 1'b1, 1'b0, '0);                  // bare idle marker
        add_row(1024, 700, pack_frame(1024, 1024, 1024, 1024, 1, 1, 0, 0, 0, 0, 0, 0, 1024),
                18, 1'b1, 1'b1, neutral_word);
        add_row(1024, 700, pack_frame(1024, 1024, 1024, 1024, 1, 1, 16'h0001, 16'h8000,
                16'hFFFF, 8'h01, 8'h80, 16'hA5A5, 16'hFFFF), 18, 1'b1, 1'b0, '0);
        add_row(1024, 700, pack_frame(1724, 324, 1024, 1024, 2, 3, 16'hFFFF, 16'h0001,
                16'h8000, 8'h00, 8'hFF, 16'hFFFF, 16'h0000), 18, 1'b1, 1'b0, '0);
        add_row(1024, 700, pack_frame(1024, 1024, 1024, 1725, 1, 1, 0, 0, 0, 0, 0, 16'h00FF, 0),
                18, 1'b1, 1'b1, err_word);                          // stick just over
        add_row(1024, 700, pack_frame(1024, 323, 1024, 1024, 1, 1, 0, 0, 0, 0, 0, 0, 0),
                18, 1'b1, 1'b1, err_word);                          // stick just under
        add_row(1024, 700, pack_frame(1024, 1024, 1024, 1024, 0, 3, 0, 0, 0, 0, 0, 0, 0),
                18, 1'b1, 1'b1, err_word);                          // first switch zero
        add_row(1024, 700, pack_frame(1024, 1024, 1024, 1024, 3, 0, 0, 0, 0, 0, 0, 0, 0),
                18, 1'b1, 1'b1, err_word);                          // second switch zero
        add_row(1024, 700, '1, 17, 1'b1, 1'b0, '0);                 // short frame
        add_row(1024, 700, '1, 40, 1'b1, 1'b0, '0);                 // oversize, count saturates
        add_row(1024, 700, '0, 19, 1'b1, 1'b0, '0);                 // one byte too many
        add_row(1024, 700, pack_frame(1024, 1024, 1024, 1024, 1, 2, 0, 0, 0, 8'h7F, 0,
                16'hFFFF, 1024), 18, 1'b1, 1'b0, '0);               // keys after an error
        add_row(0, 1024, pack_frame(1024, 0, 1000, 5, 3, 2, 0, 0, 0, 0, 0, 0, 0),
                18, 1'b1, 1'b0, '0);                                // stick saturates high
        add_row(0, 1024, pack_frame(1025, 0, 0, 0, 3, 3, 0, 0, 0, 0, 0, 0, 0),
                18, 1'b1, 1'b1, err_word);
        add_row(2047, 1024, pack_frame(1023, 2047, 1500, 1100, 2, 2, 16'h1234, 16'hFFFF,
                16'h7FFF, 8'h01, 8'h01, 16'h8001, 0), 18, 1'b1, 1'b0, '0);
        add_row(2047, 0, pack_frame(2047, 2047, 2047, 2047, 2, 3, 0, 0, 0, 0, 0, 16'h7FFE, 0),
                18, 1'b1, 1'b0, '0);
        add_row(2047, 0, pack_frame(2047, 2046, 2047, 2047, 2, 3, 0, 0, 0, 0, 0, 0, 0),
                18, 1'b1, 1'b1, err_word);
        add_row(0, 0, pack_frame(0, 0, 0, 0, 3, 3, 0, 0, 0, 0, 0, 0, 16'hFFFF),
                18, 1'b1, 1'b0, '0);

        // Hold reset low, then release it once for good
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge aclk);

        // Walk the table; the first rows run on the reset register values
        foreach (dir_rows[k]) begin
            if (dir_rows[k].offset != cur_offset || dir_rows[k].limit != cur_limit) begin
                settle();
                set_regs(dir_rows[k].offset, dir_rows[k].limit);
            end
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            send_frame(dir_rows[k].frame, dir_rows[k].nbytes, dir_rows[k].with_idle,
                       dir_rows[k].typed_ok, dir_rows[k].typed);
        end

        // Random phases: mostly well-formed frames with random content near
        // the centre, the rest short, oversize, unterminated or stray idles.
        phase = 0;
        while (phase < 5) begin
            settle();
            case (phase % 5)
                0: set_regs(0, 1024);
                1: set_regs(2047, 1024);
                2: set_regs(1024, 700);
                3: set_regs(11'($urandom_range(0, 2047)), 0);
                default: set_regs(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 1024)));
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < RAND_WORDS / 5) begin
                src_burst  = ($urandom_range(0, 4) == 0);
                sink_burst = ($urandom_range(0, 4) == 0);
                kind = $urandom_range(0, 99);
                f = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
                if (kind < 70) begin
                    for (int c = 0; c < 4; c++) begin
                        if ($urandom_range(0, 9) == 0) begin
                            v = $urandom_range(0, 2047);
                        end else if ($urandom_range(0, 7) == 0) begin
                            v = int'(cur_offset) + ($urandom_range(0, 1) ? int'(cur_limit)
                                                                         : -int'(cur_limit));
                        end else begin
                            v = int'(cur_offset) + int'($urandom_range(0, 2 * cur_limit))
                                - int'(cur_limit);
                        end
                        if (v < 0) v = 0;
                        if (v > 2047) v = 2047;
                        ch[c] = v[10:0];
                    end
                    for (int s = 0; s < 2; s++)
                        sw[s] = ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
                    f = pack_frame(ch[0], ch[1], ch[2], ch[3], sw[0], sw[1],
                                   16'($urandom), 16'($urandom), 16'($urandom),
                                   $urandom_range(0, 1) ? 8'($urandom) : 8'd0,
                                   $urandom_range(0, 1) ? 8'($urandom) : 8'd0,
                                   $urandom_range(0, 3) ? 16'($urandom) : 16'd0,
                                   16'($urandom));
                    send_frame(f, FRAME_LEN, 1'b1, 1'b0, '0);
                end else if (kind < 80) begin
                    send_frame(f, $urandom_range(0, 17), 1'b1, 1'b0, '0);
                end else if (kind < 88) begin
                    send_frame(f, $urandom_range(19, 40), 1'b1, 1'b0, '0);
                end else if (kind < 96) begin
                    send_frame(f, $urandom_range(1, 25), 1'b0, 1'b0, '0);
                end else begin
                    send_frame(f, 0, 1'b1, 1'b0, '0);
                end
            end
            phase++;
        end

        // Drain, then allow the pipe to show any stray word
        settle();
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d words under %0d register settings: %0d frames decoded,",
                 words_sent, settings_used, frames_decoded);
        $display("%0d flagged as errors, %0d dropped at the idle marker; %0d mismatches.",
                 frames_flagged, frames_dropped, fail_count);
        if (fail_count == 0) begin
            $display("rc_receiver_frame_decoder_tb OK");
        end else begin
            $display("rc_receiver_frame_decoder_tb NOT OK");
        end
        $finish;
    end

endmodule
